FILE: rtl/lcg_pkg.sv
// lcg_pkg: shared types, constants and the quarter-wave sine table function
`timescale 1ns / 1ps

package lcg_pkg;

   // register field widths
   localparam int LEN_W   = 20;
   localparam int FADE_W  = 16;
   localparam int STEP_W  = 32;
   localparam int RAMP_W  = 24;
   localparam int AMP_W   = 15;
   localparam int MAG_W   = 15;
   localparam int SMP_W   = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // queue depths
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 8;

   // register reset values
   localparam logic [LEN_W-1:0]  CHIRP_LENGTH_RST     = 20'd32000;
   localparam logic [FADE_W-1:0] FADE_LENGTH_RST      = 16'd80;
   localparam logic [STEP_W-1:0] FIRST_PHASE_STEP_RST = 32'd53711418;
   localparam logic [RAMP_W-1:0] PHASE_STEP_RAMP_RST  = 24'd48654;
   localparam logic [STEP_W-1:0] FADE_ANGLE_STEP_RST  = 32'd13421773;
   localparam logic [AMP_W-1:0]  AMPLITUDE_RST        = 15'd2700;

   // sine polynomial in q30, odd terms of sin(pi/2 x)
   localparam longint Q30 = longint'(1) << 30;
   localparam longint POLY_COEF [5] = '{
      64'sd1686629713, -64'sd693598668, 64'sd85569304, -64'sd5026993, 64'sd172273
   };

   typedef struct packed {
      logic [LEN_W-1:0]  chirp_length;
      logic [FADE_W-1:0] fade_length;
      logic [STEP_W-1:0] first_phase_step;
      logic [RAMP_W-1:0] phase_step_ramp;
      logic [STEP_W-1:0] fade_angle_step;
      logic [AMP_W-1:0]  amplitude;
   } cfg_type;

   // one classified request, front to back
   typedef struct packed {
      logic              active;
      logic              last;
      logic              use_env;
      logic [STEP_W-1:0] env_angle;
      logic [STEP_W-1:0] phase;
   } cmd_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] sample;
      logic                    last;
      logic                    active;
   } rsp_type;

   // magnitude at distance m into a quadrant of 2^(tbits-2) steps, q0.15
   function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned m,
                                                      input int unsigned tbits);
      longint x;
      longint x2;
      longint p;
      longint y;
      longint v;
      int     i;
      x  = longint'(m) << (30 - (tbits - 2));
      x2 = (x * x) / Q30;
      p  = POLY_COEF[4];
      for (i = 3; i >= 0; i--) begin
         p = POLY_COEF[i] + (p * x2) / Q30;
      end
      y = (p * x) / Q30;
      if (y < 0) begin
         y = 0;
      end
      v = (y * 32767 + Q30 / 2) / Q30;
      if (v > 32767) begin
         v = 32767;
      end
      return v[MAG_W-1:0];
   endfunction

endpackage

FILE: rtl/lcg_fifo.sv
// lcg_fifo: small register queue with count-based full and empty
`timescale 1ns / 1ps

module lcg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/lcg_sine_rom.sv
// lcg_sine_rom: quarter-wave sine table with quadrant folding, registered read
`timescale 1ns / 1ps

module lcg_sine_rom #(
   parameter int TABLE_BITS = 10
) (
   input  logic                      clock,
   input  logic [lcg_pkg::STEP_W-1:0] angle,
   output logic [lcg_pkg::MAG_W-1:0]  magnitude,
   output logic                      negative
);

   import lcg_pkg::*;

   localparam int QUARTER = 1 << (TABLE_BITS - 2);
   localparam int M_W     = TABLE_BITS - 1;

   logic [MAG_W-1:0]      tab [QUARTER + 1];
   logic [TABLE_BITS-1:0] k;
   logic [1:0]            quad;
   logic [M_W-1:0]        r_x;
   logic [M_W-1:0]        m_in;
   logic [MAG_W-1:0]      mag_ff;
   logic                  neg_ff;

   for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
      assign tab[g] = quarter_sine(g, TABLE_BITS);
   end

   assign k    = angle[STEP_W-1 -: TABLE_BITS];
   assign quad = k[TABLE_BITS-1 -: 2];
   assign r_x  = {1'b0, k[TABLE_BITS-3:0]};
   // odd quadrants run the table backward
   assign m_in = quad[0] ? (M_W'(QUARTER) - r_x) : r_x;

   always_ff @(posedge clock) begin
      mag_ff <= tab[m_in];
      neg_ff <= quad[1];
   end

   assign magnitude = mag_ff;
   assign negative  = neg_ff;

endmodule

FILE: rtl/lcg_front.sv
// lcg_front: sweep counters and per-request classification into commands
`timescale 1ns / 1ps

module lcg_front #(
   parameter int INDEX_BITS = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  lcg_pkg::cfg_type  cfg,
   input  logic              push,
   input  logic              restart,
   input  logic              cmd_full,
   output logic              cmd_push,
   output lcg_pkg::cmd_type  cmd_data
);

   import lcg_pkg::*;

   localparam int CMP_W = ((INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W) + 1;

   logic [INDEX_BITS-1:0] index_ff, index_in, index_eff;
   logic [STEP_W-1:0]     phase_ff, phase_in, phase_eff;
   logic [STEP_W-1:0]     step_ff, step_in, step_eff;
   logic [STEP_W-1:0]     angle_ff, angle_in, angle_eff, angle_dec;
   logic                  running_ff, running_in;
   logic                  run_eff, run_now;
   logic                  fade_in, fade_out;
   logic [CMP_W-1:0]      index_x, len_x, fade_x;

   assign cmd_push = push && !cmd_full;

   always_comb begin
      index_eff = restart ? '0 : index_ff;
      phase_eff = restart ? '0 : phase_ff;
      step_eff  = restart ? cfg.first_phase_step : step_ff;
      angle_eff = restart ? '0 : angle_ff;
      run_eff   = restart || running_ff;

      index_x   = CMP_W'(index_eff);
      len_x     = CMP_W'(cfg.chirp_length);
      fade_x    = CMP_W'(cfg.fade_length);

      run_now   = run_eff && (index_x < len_x);
      fade_in   = index_x < fade_x;
      fade_out  = !fade_in && ((index_x + fade_x) > len_x);
      angle_dec = angle_eff - cfg.fade_angle_step;

      cmd_data.active    = run_now;
      cmd_data.last      = run_now && ((index_x + CMP_W'(1)) == len_x);
      cmd_data.use_env   = fade_in || fade_out;
      cmd_data.env_angle = fade_in ? angle_eff : angle_dec;
      cmd_data.phase     = phase_eff;

      index_in   = index_eff;
      phase_in   = phase_eff;
      step_in    = step_eff;
      angle_in   = angle_eff;
      running_in = run_now;
      if (run_now) begin
         index_in = index_eff + INDEX_BITS'(1);
         phase_in = phase_eff + step_eff;
         step_in  = step_eff + STEP_W'(cfg.phase_step_ramp);
         if (fade_in) begin
            angle_in = angle_eff + cfg.fade_angle_step;
         end else if (fade_out) begin
            angle_in = angle_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= '0;
         phase_ff   <= '0;
         step_ff    <= '0;
         angle_ff   <= '0;
         running_ff <= 1'b0;
      end else if (cmd_push) begin
         index_ff   <= index_in;
         phase_ff   <= phase_in;
         step_ff    <= step_in;
         angle_ff   <= angle_in;
         running_ff <= running_in;
      end
   end

endmodule

FILE: rtl/lcg_back.sv
// lcg_back: sine lookups, envelope and gain multiplies, result queue
`timescale 1ns / 1ps

module lcg_back #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [lcg_pkg::AMP_W-1:0] amplitude,
   input  lcg_pkg::cmd_type          cmd_data,
   input  logic                      cmd_empty,
   output logic                      cmd_pop,
   input  logic                      rsp_pop,
   output lcg_pkg::rsp_type          rsp_data,
   output logic                      rsp_empty
);

   import lcg_pkg::*;

   localparam int CR_W = $clog2(RSP_DEPTH + 1);

   logic [CR_W-1:0]  credit_ff, credit_in;
   logic             rsp_take;

   logic [MAG_W-1:0] ph_mag, env_mag;
   logic             ph_neg, env_neg;

   logic             s1_valid_ff;
   cmd_type          s1_cmd_ff;

   logic             s2_valid_ff;
   logic             s2_active_ff, s2_last_ff, s2_neg_ff;
   logic [29:0]      ap_ff, ap_in;
   logic [30:0]      env_ff, env_in;
   logic [29:0]      env_sq;

   logic             s3_valid_ff;
   logic             s3_active_ff, s3_last_ff, s3_neg_ff;
   logic [60:0]      prod_ff, prod_in;

   logic [SMP_W-1:0] smp_mag;
   rsp_type          rsp_push_data;
   logic             rsp_full;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   // issue only when the result queue is sure to have room
   assign cmd_pop  = !cmd_empty && (credit_ff < CR_W'(RSP_DEPTH));
   assign rsp_take = rsp_pop && !rsp_empty;

   always_comb begin
      credit_in = credit_ff;
      if (cmd_pop && !rsp_take) begin
         credit_in = credit_ff + CR_W'(1);
      end else if (rsp_take && !cmd_pop) begin
         credit_in = credit_ff - CR_W'(1);
      end
   end

   lcg_sine_rom #(.TABLE_BITS(SINE_TABLE_BITS)) u_phase_rom (
      .clock     (clock),
      .angle     (cmd_data.phase),
      .magnitude (ph_mag),
      .negative  (ph_neg)
   );

   lcg_sine_rom #(.TABLE_BITS(SINE_TABLE_BITS)) u_env_rom (
      .clock     (clock),
      .angle     (cmd_data.env_angle),
      .magnitude (env_mag),
      .negative  (env_neg)
   );

   // envelope is sin^2 so its sign drops out
   assign env_sq  = env_mag * env_mag;
   assign env_in  = s1_cmd_ff.use_env ? {1'b0, env_sq} : 31'h4000_0000;
   assign ap_in   = amplitude * ph_mag;
   assign prod_in = ap_ff * env_ff;

   always_comb begin
      smp_mag = s3_active_ff ? prod_ff[60:45] : '0;
      rsp_push_data.sample = s3_neg_ff ? signed'(SMP_W'(-smp_mag)) : signed'(smp_mag);
      rsp_push_data.last   = s3_active_ff && s3_last_ff;
      rsp_push_data.active = s3_active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         credit_ff   <= credit_in;
         s1_valid_ff <= cmd_pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff    <= cmd_data;
      s2_active_ff <= s1_cmd_ff.active;
      s2_last_ff   <= s1_cmd_ff.last;
      s2_neg_ff    <= ph_neg ^ (env_neg & 1'b0);
      ap_ff        <= ap_in;
      env_ff       <= env_in;
      s3_active_ff <= s2_active_ff;
      s3_last_ff   <= s2_last_ff;
      s3_neg_ff    <= s2_neg_ff;
      prod_ff      <= prod_in;
   end

   lcg_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(RSP_DEPTH)) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_valid_ff),
      .push_data (rsp_push_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_bits) & {$bits(rsp_type){!rsp_full || 1'b1}};

endmodule

FILE: rtl/linear_chirp_generator_with_fade.sv
// linear_chirp_generator_with_fade: top level, register file and front/back split
`timescale 1ns / 1ps

// Linear chirp source with raised-cosine taper. Every word pushed on the
// request side asks for one sample; req_restart high starts a new sweep at
// sample zero. Each sample is amplitude * sin(phase) * envelope, truncated
// toward zero, where the phase accumulator advances by a step that itself
// grows by phase_step_ramp every sample, and the envelope is sin^2 of an
// envelope angle over the first fade_length samples and the last
// fade_length-1 samples, full scale in between. After the final sample
// (flagged by rsp_last) the block answers with zero and rsp_active low until
// the next restart. Software should keep chirp_length at least twice
// fade_length. Registers are written over the csr port, which is always
// ready; write them only while no request is outstanding. Timing: the front
// part updates the sweep counters for each request it takes, so a request is
// taken every clock while the four-entry command queue has room; the back
// part is a three-stage pipeline (table read, two parallel 15x15 multiplies,
// one 30x31 multiply). Sustained rate is one word per clock, limited by the
// result queue only when the consumer stops popping.

module linear_chirp_generator_with_fade #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int INDEX_BITS      = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   // request queue side
   input  logic                                push,
   output logic                                full,
   input  logic                                req_restart,
   // result queue side
   output logic                                empty,
   input  logic                                pop,
   output logic signed [lcg_pkg::SMP_W-1:0]    rsp_sample,
   output logic                                rsp_last,
   output logic                                rsp_active,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lcg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lcg_pkg::CSR_DATA_W-1:0]      csr_data
);

   import lcg_pkg::*;

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CHIRP_LENGTH     = 3'd0,
      REG_FADE_LENGTH      = 3'd1,
      REG_FIRST_PHASE_STEP = 3'd2,
      REG_PHASE_STEP_RAMP  = 3'd3,
      REG_FADE_ANGLE_STEP  = 3'd4,
      REG_AMPLITUDE        = 3'd5
   } csr_reg_type;

   cfg_type  cfg_ff, cfg_in;

   logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type  cmd_wr, cmd_rd;
   logic [$bits(cmd_type)-1:0] cmd_rd_bits;
   rsp_type  rsp_word;

   assign csr_ready = 1'b1;

   // register file, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            REG_CHIRP_LENGTH:     cfg_in.chirp_length     = csr_data[LEN_W-1:0];
            REG_FADE_LENGTH:      cfg_in.fade_length      = csr_data[FADE_W-1:0];
            REG_FIRST_PHASE_STEP: cfg_in.first_phase_step = csr_data[STEP_W-1:0];
            REG_PHASE_STEP_RAMP:  cfg_in.phase_step_ramp  = csr_data[RAMP_W-1:0];
            REG_FADE_ANGLE_STEP:  cfg_in.fade_angle_step  = csr_data[STEP_W-1:0];
            REG_AMPLITUDE:        cfg_in.amplitude        = csr_data[AMP_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chirp_length     <= CHIRP_LENGTH_RST;
         cfg_ff.fade_length      <= FADE_LENGTH_RST;
         cfg_ff.first_phase_step <= FIRST_PHASE_STEP_RST;
         cfg_ff.phase_step_ramp  <= PHASE_STEP_RAMP_RST;
         cfg_ff.fade_angle_step  <= FADE_ANGLE_STEP_RST;
         cfg_ff.amplitude        <= AMPLITUDE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: sweep state and classification, one request per clock while the command queue has room
   lcg_front #(.INDEX_BITS(INDEX_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .restart  (req_restart),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wr)
   );

   // command queue decouples the counters from the multiply pipeline
   lcg_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd_bits),
      .empty     (cmd_empty)
   );

   assign cmd_rd = cmd_type'(cmd_rd_bits);
   assign full   = cmd_full;

   // back: table lookups, multiplies and the result queue
   lcg_back #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .amplitude (cfg_ff.amplitude),
      .cmd_data  (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (pop),
      .rsp_data  (rsp_word),
      .rsp_empty (empty)
   );

   assign rsp_sample = rsp_word.sample;
   assign rsp_last   = rsp_word.last;
   assign rsp_active = rsp_word.active;

endmodule
